// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define I2CMRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define I2CMRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/i2cmrr_pkg.sv
// ----------------------------------------------------------------------------
// I2C register read package
// Types and constants used by the front end, command queue and bus engine.
// ----------------------------------------------------------------------------
package i2cmrr_pkg;

  // slave address after reset
  localparam logic [6:0] DEV_ADDR_RESET = 7'd64;
  // bit counter value of the last bit in a byte
  localparam logic [2:0] LAST_BIT = 3'd7;

  // item kind after classification
  typedef enum logic {
    CMD_TICK    = 1'b0,
    CMD_REQUEST = 1'b1
  } cmd_kind_e;

  // classified item travelling through the queue
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] pointer;
    logic       sda;
  } cmd_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // bus phases, one-hot
  typedef enum logic [30:0] {
    PH_IDLE   = 31'h00000001,
    PH_S1A    = 31'h00000002,
    PH_S1B    = 31'h00000004,
    PH_WLOW   = 31'h00000008,
    PH_WHIGH  = 31'h00000010,
    PH_WALOW  = 31'h00000020,
    PH_WAHIGH = 31'h00000040,
    PH_PLOW   = 31'h00000080,
    PH_PHIGH  = 31'h00000100,
    PH_PALOW  = 31'h00000200,
    PH_PAHIGH = 31'h00000400,
    PH_T1A    = 31'h00000800,
    PH_T1B    = 31'h00001000,
    PH_T1C    = 31'h00002000,
    PH_S2A    = 31'h00004000,
    PH_S2B    = 31'h00008000,
    PH_RLOW   = 31'h00010000,
    PH_RHIGH  = 31'h00020000,
    PH_RALOW  = 31'h00040000,
    PH_RAHIGH = 31'h00080000,
    PH_HLOW   = 31'h00100000,
    PH_HHIGH  = 31'h00200000,
    PH_MALOW  = 31'h00400000,
    PH_MAHIGH = 31'h00800000,
    PH_LLOW   = 31'h01000000,
    PH_LHIGH  = 31'h02000000,
    PH_NALOW  = 31'h04000000,
    PH_NAHIGH = 31'h08000000,
    PH_T2A    = 31'h10000000,
    PH_T2B    = 31'h20000000,
    PH_T2C    = 31'h40000000
  } phase_e;

endpackage

// File: hw/rtl/i2cmrr_front.sv
// ----------------------------------------------------------------------------
// I2C register read front end
// Accepts input transactions, classifies them and pushes them to the queue.
// ----------------------------------------------------------------------------
module i2cmrr_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   mode_i,
  input  logic [7:0]             register_pointer_i,
  input  logic                   sda_sample_i,
  input  i2cmrr_pkg::q_status_t  q_status_i,
  output logic                   push_o,
  output i2cmrr_pkg::cmd_t       cmd_o
);

  logic             valid_q, valid_d;
  i2cmrr_pkg::cmd_t cmd_q, cmd_d;
  logic             accept;

  // hand the held item over whenever the queue has room
  assign push_o     = valid_q & ~q_status_i.full;
  assign in_stall_o = valid_q & q_status_i.full;
  assign accept     = in_valid_i & ~in_stall_o;
  assign cmd_o      = cmd_q;

  // classification
  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d     = 1'b1;
      cmd_d.kind  = mode_i ? i2cmrr_pkg::CMD_REQUEST : i2cmrr_pkg::CMD_TICK;
      cmd_d.pointer = register_pointer_i;
      cmd_d.sda   = sda_sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

// File: hw/rtl/i2cmrr_queue.sv
// ----------------------------------------------------------------------------
// I2C register read command queue
// Short FIFO between the front end and the bus engine.
// ----------------------------------------------------------------------------
module i2cmrr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  i2cmrr_pkg::cmd_t       push_cmd_i,
  input  logic                   pop_i,
  output i2cmrr_pkg::cmd_t       head_cmd_o,
  output i2cmrr_pkg::q_status_t  status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  i2cmrr_pkg::cmd_t   slot_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign head_cmd_o     = slot_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// File: hw/rtl/i2cmrr_engine.sv
// ----------------------------------------------------------------------------
// I2C register read bus engine
// Steps the bus phase sequence, one queued command per cycle while the
// output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module i2cmrr_engine (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [6:0]             cfg_data_i,
  input  i2cmrr_pkg::q_status_t  q_status_i,
  input  i2cmrr_pkg::cmd_t       head_cmd_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   scl_level_o,
  output logic                   sda_release_o,
  output logic                   busy_res_o,
  output logic                   done_res_o,
  output logic [15:0]            read_word_o,
  output logic                   ack_missing_o
);

  i2cmrr_pkg::phase_e phase_q, phase_d;
  logic [6:0]  dev_addr_q;
  logic [2:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  ptr_q, ptr_d;
  logic [15:0] word_q, word_d;
  logic        nack_q, nack_d;
  logic        scl_hold_q, scl_hold_d;
  logic        sda_hold_q, sda_hold_d;
  logic        out_valid_q;
  logic        scl, sdo, done, txbit, sda, last;

  // take the next command when the output slot is free or draining
  assign pop_o       = ~q_status_i.empty & (~out_valid_q | ~out_stall_i);
  assign out_valid_o = out_valid_q;
  assign txbit       = shift_q[7];
  assign sda         = head_cmd_i.sda;
  assign last        = (bit_q == i2cmrr_pkg::LAST_BIT);

  // one bus phase per tick
  always_comb begin
    phase_d    = phase_q;
    bit_d      = bit_q;
    shift_d    = shift_q;
    ptr_d      = ptr_q;
    word_d     = word_q;
    nack_d     = nack_q;
    scl_hold_d = scl_hold_q;
    sda_hold_d = sda_hold_q;
    scl        = scl_hold_q;
    sdo        = sda_hold_q;
    done       = 1'b0;
    if (pop_o) begin
      if (head_cmd_i.kind == i2cmrr_pkg::CMD_REQUEST) begin
        // requests while busy are dropped
        if (phase_q == i2cmrr_pkg::PH_IDLE) begin
          ptr_d   = head_cmd_i.pointer;
          nack_d  = 1'b0;
          bit_d   = '0;
          shift_d = {dev_addr_q, 1'b0};
          phase_d = i2cmrr_pkg::PH_S1A;
        end
      end else begin
        case (phase_q)
          i2cmrr_pkg::PH_S1A: begin
            scl = 1'b1; sdo = 1'b1; phase_d = i2cmrr_pkg::PH_S1B;
          end
          i2cmrr_pkg::PH_S1B: begin
            scl = 1'b1; sdo = 1'b0; phase_d = i2cmrr_pkg::PH_WLOW;
          end
          i2cmrr_pkg::PH_WLOW: begin
            scl = 1'b0; sdo = txbit; phase_d = i2cmrr_pkg::PH_WHIGH;
          end
          i2cmrr_pkg::PH_WHIGH: begin
            scl = 1'b1; sdo = txbit;
            shift_d = {shift_q[6:0], 1'b0};
            bit_d   = bit_q + 1'b1;
            phase_d = last ? i2cmrr_pkg::PH_WALOW : i2cmrr_pkg::PH_WLOW;
          end
          i2cmrr_pkg::PH_WALOW: begin
            scl = 1'b0; sdo = 1'b1; phase_d = i2cmrr_pkg::PH_WAHIGH;
          end
          i2cmrr_pkg::PH_WAHIGH: begin
            scl = 1'b1; sdo = 1'b1;
            nack_d  = nack_q | sda;
            shift_d = ptr_q;
            bit_d   = '0;
            phase_d = i2cmrr_pkg::PH_PLOW;
          end
          i2cmrr_pkg::PH_PLOW: begin
            scl = 1'b0; sdo = txbit; phase_d = i2cmrr_pkg::PH_PHIGH;
          end
          i2cmrr_pkg::PH_PHIGH: begin
            scl = 1'b1; sdo = txbit;
            shift_d = {shift_q[6:0], 1'b0};
            bit_d   = bit_q + 1'b1;
            phase_d = last ? i2cmrr_pkg::PH_PALOW : i2cmrr_pkg::PH_PLOW;
          end
          i2cmrr_pkg::PH_PALOW: begin
            scl = 1'b0; sdo = 1'b1; phase_d = i2cmrr_pkg::PH_PAHIGH;
          end
          i2cmrr_pkg::PH_PAHIGH: begin
            scl = 1'b1; sdo = 1'b1;
            nack_d  = nack_q | sda;
            phase_d = i2cmrr_pkg::PH_T1A;
          end
          i2cmrr_pkg::PH_T1A: begin
            scl = 1'b0; sdo = 1'b0; phase_d = i2cmrr_pkg::PH_T1B;
          end
          i2cmrr_pkg::PH_T1B: begin
            scl = 1'b1; sdo = 1'b0; phase_d = i2cmrr_pkg::PH_T1C;
          end
          i2cmrr_pkg::PH_T1C: begin
            scl = 1'b1; sdo = 1'b1; phase_d = i2cmrr_pkg::PH_S2A;
          end
          i2cmrr_pkg::PH_S2A: begin
            scl = 1'b1; sdo = 1'b1; phase_d = i2cmrr_pkg::PH_S2B;
          end
          i2cmrr_pkg::PH_S2B: begin
            // repeated start, address taken now for the read byte
            scl = 1'b1; sdo = 1'b0;
            shift_d = {dev_addr_q, 1'b1};
            bit_d   = '0;
            phase_d = i2cmrr_pkg::PH_RLOW;
          end
          i2cmrr_pkg::PH_RLOW: begin
            scl = 1'b0; sdo = txbit; phase_d = i2cmrr_pkg::PH_RHIGH;
          end
          i2cmrr_pkg::PH_RHIGH: begin
            scl = 1'b1; sdo = txbit;
            shift_d = {shift_q[6:0], 1'b0};
            bit_d   = bit_q + 1'b1;
            phase_d = last ? i2cmrr_pkg::PH_RALOW : i2cmrr_pkg::PH_RLOW;
          end
          i2cmrr_pkg::PH_RALOW: begin
            scl = 1'b0; sdo = 1'b1; phase_d = i2cmrr_pkg::PH_RAHIGH;
          end
          i2cmrr_pkg::PH_RAHIGH: begin
            scl = 1'b1; sdo = 1'b1;
            nack_d  = nack_q | sda;
            shift_d = '0;
            bit_d   = '0;
            phase_d = i2cmrr_pkg::PH_HLOW;
          end
          i2cmrr_pkg::PH_HLOW: begin
            scl = 1'b0; sdo = 1'b1; phase_d = i2cmrr_pkg::PH_HHIGH;
          end
          i2cmrr_pkg::PH_HHIGH: begin
            scl = 1'b1; sdo = 1'b1;
            shift_d = {shift_q[6:0], sda};
            bit_d   = bit_q + 1'b1;
            if (last) begin
              phase_d = i2cmrr_pkg::PH_MALOW;
              word_d  = {shift_q[6:0], sda, 8'h00};
            end else begin
              phase_d = i2cmrr_pkg::PH_HLOW;
            end
          end
          i2cmrr_pkg::PH_MALOW: begin
            scl = 1'b0; sdo = 1'b0; phase_d = i2cmrr_pkg::PH_MAHIGH;
          end
          i2cmrr_pkg::PH_MAHIGH: begin
            scl = 1'b1; sdo = 1'b0;
            shift_d = '0;
            bit_d   = '0;
            phase_d = i2cmrr_pkg::PH_LLOW;
          end
          i2cmrr_pkg::PH_LLOW: begin
            scl = 1'b0; sdo = 1'b1; phase_d = i2cmrr_pkg::PH_LHIGH;
          end
          i2cmrr_pkg::PH_LHIGH: begin
            scl = 1'b1; sdo = 1'b1;
            shift_d = {shift_q[6:0], sda};
            bit_d   = bit_q + 1'b1;
            if (last) begin
              phase_d = i2cmrr_pkg::PH_NALOW;
              word_d  = {word_q[15:8], shift_q[6:0], sda};
            end else begin
              phase_d = i2cmrr_pkg::PH_LLOW;
            end
          end
          i2cmrr_pkg::PH_NALOW: begin
            scl = 1'b0; sdo = 1'b1; phase_d = i2cmrr_pkg::PH_NAHIGH;
          end
          i2cmrr_pkg::PH_NAHIGH: begin
            scl = 1'b1; sdo = 1'b1; phase_d = i2cmrr_pkg::PH_T2A;
          end
          i2cmrr_pkg::PH_T2A: begin
            scl = 1'b0; sdo = 1'b0; phase_d = i2cmrr_pkg::PH_T2B;
          end
          i2cmrr_pkg::PH_T2B: begin
            scl = 1'b1; sdo = 1'b0; phase_d = i2cmrr_pkg::PH_T2C;
          end
          i2cmrr_pkg::PH_T2C: begin
            scl = 1'b1; sdo = 1'b1; done = 1'b1;
            phase_d = i2cmrr_pkg::PH_IDLE;
          end
          default: begin
            // idle, or an illegal code: release both lines
            scl = 1'b1; sdo = 1'b1; phase_d = i2cmrr_pkg::PH_IDLE;
          end
        endcase
        scl_hold_d = scl;
        sda_hold_d = sdo;
      end
    end
  end

  // control and bus state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= i2cmrr_pkg::PH_IDLE;
      dev_addr_q  <= i2cmrr_pkg::DEV_ADDR_RESET;
      bit_q       <= '0;
      shift_q     <= '0;
      ptr_q       <= '0;
      word_q      <= '0;
      nack_q      <= 1'b0;
      scl_hold_q  <= 1'b1;
      sda_hold_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      bit_q      <= bit_d;
      shift_q    <= shift_d;
      ptr_q      <= ptr_d;
      word_q     <= word_d;
      nack_q     <= nack_d;
      scl_hold_q <= scl_hold_d;
      sda_hold_q <= sda_hold_d;
      if (cfg_valid_i) begin
        dev_addr_q <= cfg_data_i;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register, held while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      scl_level_o   <= scl;
      sda_release_o <= sdo;
      busy_res_o    <= (phase_d != i2cmrr_pkg::PH_IDLE);
      done_res_o    <= done;
      read_word_o   <= word_d;
      ack_missing_o <= nack_d;
    end
  end

endmodule

// File: hw/rtl/i2c_master_register_read_core.sv
// ----------------------------------------------------------------------------
// I2C master 16-bit register read core
// Front end, command queue and bus engine for a single register read.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): mode_i = 1 starts a register
//   read of register_pointer_i, mode_i = 0 is a tick that advances the bus
//   by one phase and carries the SDA level in sda_sample_i.
//   Output channel (out_valid_o / out_stall_i): one result per input
//   transaction with SCL, SDA drive, busy, done, the word and the ACK flag.
//   Config channel (cfg_valid_i / cfg_ready_o): seven-bit slave address,
//   always ready; write it only while the core is idle.
//   A result passes the front register, the queue and the output register
//   after its input transaction is accepted; one transaction per cycle is
//   sustained while out_stall_i is low.
//   A short queue between the front register and the engine absorbs
//   output stalls; the input stalls only once the queue is full.
//   Reset sets the held SCL and SDA levels to released, empties the queue,
//   returns to idle and sets the slave address to 64.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_master_register_read_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  // input transactions
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  register_pointer_i,
  input  logic        sda_sample_i,
  // result transactions
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_level_o,
  output logic        sda_release_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [15:0] read_word_o,
  output logic        ack_missing_o
);

  logic                  push, pop;
  i2cmrr_pkg::cmd_t      push_cmd, head_cmd;
  i2cmrr_pkg::q_status_t q_status;
  logic                  bus_released;

  assign cfg_ready_o = 1'b1;

  // classification
  i2cmrr_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .register_pointer_i (register_pointer_i),
    .sda_sample_i       (sda_sample_i),
    .q_status_i         (q_status),
    .push_o             (push),
    .cmd_o              (push_cmd)
  );

  // decoupling queue
  i2cmrr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_cmd_o (head_cmd),
    .status_o   (q_status)
  );

  // bus sequencing
  i2cmrr_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .q_status_i    (q_status),
    .head_cmd_i    (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .scl_level_o   (scl_level_o),
    .sda_release_o (sda_release_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .read_word_o   (read_word_o),
    .ack_missing_o (ack_missing_o)
  );

  assign bus_released = !busy_res_o && scl_level_o && sda_release_o;

  // a completed read leaves the bus released and the core idle
  `I2CMRR_ASSERT(a_done_idle, !(out_valid_o && done_res_o) || bus_released, "bus held at done")
  // the front never pushes into a full queue
  `I2CMRR_ASSERT(a_no_overflow, !push || !q_status.full, "queue overflow")
  // the engine never pops an empty queue
  `I2CMRR_ASSERT(a_no_underflow, !pop || !q_status.empty, "queue underflow")
  // a pop always produces a result in the output register
  `I2CMRR_ASSERT_NEXT(a_pop_result, pop, out_valid_o, "popped command gave no result")

endmodule
